// ===== rtl/npcq_pkg.sv =====
package npcq_pkg;

   localparam int IDX_W  = 6;
   localparam int COMP_W = 8;
   localparam int SQ_W   = 2 * COMP_W;
   localparam int DIST_W = 18;

   // function codes of an input item
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   typedef struct packed {
      logic              func;
      logic [IDX_W-1:0]  entry_index;
      logic [COMP_W-1:0] in_red;
      logic [COMP_W-1:0] in_green;
      logic [COMP_W-1:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  best_index;
      logic [COMP_W-1:0] out_red;
      logic [COMP_W-1:0] out_green;
      logic [COMP_W-1:0] out_blue;
      logic [DIST_W-1:0] best_distance;
   } rsp_type;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } rgb_type;

   localparam int RGB_W = $bits(rgb_type);

endpackage

// ===== rtl/nearest_palette_color_quantizer_top.sv =====
// Nearest-palette color quantizer. The codebook of CODEBOOK_SIZE RGB entries (8 bits per
// component, all zero after reset) sits in a single-port-write, registered-read RAM. A load
// item (func = 0) writes one entry in the cycle it is accepted and gives no result; an
// entry_index not below CODEBOOK_SIZE is ignored. A pixel item (func = 1) sweeps the whole
// codebook, one RAM read per cycle, and returns the closest entry by squared RGB distance,
// the lowest index winning ties. A pixel's candidates pass the RAM read register, the
// squared-difference stage and the running minimum; the result then goes to the output
// register and rsp_valid, and the next item is taken once the sequencer is idle again. The
// sweep is serial as the codebook RAM has one read port; a load leaves the sequencer idle.
// A finished result sits in an output register, so the block keeps taking items while rsp
// is stalled; a second pixel then waits at the end of its sweep until the first result is
// taken. best_index carries the low 6 bits of the winning index. No clearing pass is needed
// after reset: a flop per entry marks it loaded, and an entry never loaded reads as zero.
module nearest_palette_color_quantizer_top #(
   parameter int CODEBOOK_SIZE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  npcq_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output npcq_pkg::rsp_type rsp_item
);

   localparam int AW = (CODEBOOK_SIZE > 1) ? $clog2(CODEBOOK_SIZE) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(CODEBOOK_SIZE - 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic                        req_accept;
   logic                        rsp_free;

   // codebook write side
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [CODEBOOK_SIZE-1:0]    loaded_ff;

   // sweep side
   logic [AW-1:0]               rd_addr_ff, rd_addr_in;
   logic                        rd_vld_ff;
   logic                        rd_last_ff;
   logic [AW-1:0]               rd_idx_ff;
   logic                        rd_loaded_ff;
   logic [npcq_pkg::RGB_W-1:0]  ram_rd_data;
   npcq_pkg::rgb_type           cand_color;
   npcq_pkg::rgb_type           pixel_ff;

   // search results
   logic                        srch_done;
   logic [AW-1:0]               best_index;
   npcq_pkg::rgb_type           best_color;
   logic [npcq_pkg::DIST_W-1:0] best_dist;

   // output register
   logic                        rsp_valid_ff;
   npcq_pkg::rsp_type           rsp_item_ff;
   logic                        rsp_load;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // loads beyond the codebook are dropped
   assign wr_en   = req_accept && (req_item.func == npcq_pkg::FUNC_LOAD)
                 && (int'(req_item.entry_index) < CODEBOOK_SIZE);
   assign wr_addr = AW'(req_item.entry_index);

   npcq_ram #(
      .WIDTH (npcq_pkg::RGB_W),
      .DEPTH (CODEBOOK_SIZE)
   ) u_codebook (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_item.in_red, req_item.in_green, req_item.in_blue}),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   // per-entry loaded flags stand in for clearing the RAM at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
      end else if (wr_en) begin
         loaded_ff[wr_addr] <= 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      rd_addr_in = rd_addr_ff;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_item.func == npcq_pkg::FUNC_PIXEL)) begin
               state_in   = ST_SWEEP;
               rd_addr_in = '0;
            end
         end
         ST_SWEEP: begin
            rd_addr_in = rd_addr_ff + AW'(1);
            if (rd_addr_ff == LAST_ADDR) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (srch_done) begin
               if (rsp_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= (state_ff == ST_SWEEP);
      end
      rd_addr_ff   <= rd_addr_in;
      rd_last_ff   <= (rd_addr_ff == LAST_ADDR);
      rd_idx_ff    <= rd_addr_ff;
      rd_loaded_ff <= loaded_ff[rd_addr_ff];
      if (req_accept) begin
         pixel_ff <= '{red:   req_item.in_red,
                       green: req_item.in_green,
                       blue:  req_item.in_blue};
      end
   end

   // entries never loaded take part as black
   assign cand_color = rd_loaded_ff ? npcq_pkg::rgb_type'(ram_rd_data) : '0;

   npcq_search #(
      .AW (AW)
   ) u_search (
      .clock      (clock),
      .reset      (reset),
      .pixel      (pixel_ff),
      .cand_valid (rd_vld_ff),
      .cand_last  (rd_last_ff),
      .cand_index (rd_idx_ff),
      .cand_color (cand_color),
      .done       (srch_done),
      .best_index (best_index),
      .best_color (best_color),
      .best_dist  (best_dist)
   );

   // output register, holds while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_item_ff.best_index    <= npcq_pkg::IDX_W'(best_index);
         rsp_item_ff.out_red       <= best_color.red;
         rsp_item_ff.out_green     <= best_color.green;
         rsp_item_ff.out_blue      <= best_color.blue;
         rsp_item_ff.best_distance <= best_dist;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== rtl/npcq_ram.sv =====
module npcq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/npcq_search.sv =====
module npcq_search #(
   parameter int AW = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  npcq_pkg::rgb_type          pixel,
   input  logic                       cand_valid,
   input  logic                       cand_last,
   input  logic [AW-1:0]              cand_index,
   input  npcq_pkg::rgb_type          cand_color,
   output logic                       done,
   output logic [AW-1:0]              best_index,
   output npcq_pkg::rgb_type          best_color,
   output logic [npcq_pkg::DIST_W-1:0] best_dist
);

   // stage 1: squared component differences
   logic                        s1_vld_ff;
   logic                        s1_last_ff;
   logic [AW-1:0]               s1_idx_ff;
   npcq_pkg::rgb_type           s1_color_ff;
   logic [npcq_pkg::SQ_W-1:0]   sq_r_ff, sq_g_ff, sq_b_ff;
   logic [npcq_pkg::SQ_W-1:0]   sq_r_in, sq_g_in, sq_b_in;

   // stage 2: running minimum
   logic                        done_ff;
   logic [AW-1:0]               best_idx_ff;
   npcq_pkg::rgb_type           best_color_ff;
   logic [npcq_pkg::DIST_W-1:0] best_dist_ff;
   logic [npcq_pkg::DIST_W-1:0] cand_dist;
   logic                        take;

   function automatic logic [npcq_pkg::SQ_W-1:0] sq_diff(
      input logic [npcq_pkg::COMP_W-1:0] a,
      input logic [npcq_pkg::COMP_W-1:0] b
   );
      logic [npcq_pkg::COMP_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return npcq_pkg::SQ_W'(d) * npcq_pkg::SQ_W'(d);
   endfunction

   always_comb begin
      sq_r_in = sq_diff(pixel.red,   cand_color.red);
      sq_g_in = sq_diff(pixel.green, cand_color.green);
      sq_b_in = sq_diff(pixel.blue,  cand_color.blue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cand_valid;
      end
      s1_last_ff  <= cand_last;
      s1_idx_ff   <= cand_index;
      s1_color_ff <= cand_color;
      sq_r_ff     <= sq_r_in;
      sq_g_ff     <= sq_g_in;
      sq_b_ff     <= sq_b_in;
   end

   assign cand_dist = npcq_pkg::DIST_W'(sq_r_ff) + npcq_pkg::DIST_W'(sq_g_ff)
                    + npcq_pkg::DIST_W'(sq_b_ff);

   // first entry always taken, later ones only when strictly closer
   assign take = s1_vld_ff && ((s1_idx_ff == '0) || (cand_dist < best_dist_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= s1_vld_ff && s1_last_ff;
      end
      if (take) begin
         best_idx_ff   <= s1_idx_ff;
         best_color_ff <= s1_color_ff;
         best_dist_ff  <= cand_dist;
      end
   end

   assign done       = done_ff;
   assign best_index = best_idx_ff;
   assign best_color = best_color_ff;
   assign best_dist  = best_dist_ff;

endmodule
